// ===== sv/jpgf_pkg.sv =====
// ----------------------------------------------------------------------------
// jpgf_pkg
// Shared types, register codes and axis limit table for the position glitch
// filter.
// ----------------------------------------------------------------------------
package jpgf_pkg;

   localparam int AXES       = 32;
   localparam int SLOT_W     = 6;
   localparam int SLOTS      = 64;
   localparam int POS_W      = 16;
   localparam int CFG_W      = 15;
   localparam int COUNT_W    = 16;
   localparam int CSR_ADDR_W = 3;

   // register index codes, taken from paddr[2]
   localparam logic REG_RANGE_MARGIN = 1'b0;
   localparam logic REG_MAX_JUMP     = 1'b1;

   localparam logic [CFG_W-1:0] MARGIN_RESET = 15'd2048;
   localparam logic [CFG_W-1:0] JUMP_RESET   = 15'd2048;

   typedef logic [SLOT_W-1:0]        slot_type;
   typedef logic signed [POS_W-1:0]  pos_type;

   typedef struct packed {
      logic [CFG_W-1:0] range_margin;
      logic [CFG_W-1:0] max_jump;
   } cfg_type;

   // entries 0..31 joint axes, 32..63 motor axes
   localparam pos_type LIMIT_LO [SLOTS] = '{
      -16'sd6431, -16'sd1270, -16'sd3564, -16'sd8192, -16'sd1352, -16'sd6431,
      16'sd0, -16'sd2867, -16'sd1434, -16'sd8192, -16'sd9421, -16'sd6431,
      16'sd0, -16'sd2867, -16'sd1434, -16'sd12866, -16'sd696, -16'sd6431,
      -16'sd9421, -16'sd6431, -16'sd5001, -16'sd2662, -16'sd12866, -16'sd12861,
      -16'sd6431, -16'sd9421, -16'sd6431, -16'sd3564, -16'sd2662, -16'sd5001,
      -16'sd2130, -16'sd32768,
      -16'sd6431, -16'sd1393, -16'sd1393, -16'sd8192, -16'sd1352, -16'sd6431,
      16'sd0, -16'sd2580, -16'sd2527, -16'sd8192, -16'sd9421, -16'sd6431,
      16'sd0, -16'sd2580, -16'sd2527, -16'sd12866, -16'sd696, -16'sd6431,
      -16'sd9421, -16'sd6431, -16'sd4014, -16'sd4014, -16'sd12866, -16'sd12861,
      -16'sd6431, -16'sd9421, -16'sd6431, -16'sd3072, -16'sd3072, -16'sd5001,
      -16'sd2130, -16'sd32768
   };

   localparam pos_type LIMIT_HI [SLOTS] = '{
      16'sd6431, 16'sd1270, 16'sd1147, 16'sd1966, 16'sd9421, 16'sd6431,
      16'sd9339, 16'sd2859, 16'sd1430, 16'sd1966, 16'sd1352, 16'sd6431,
      16'sd9339, 16'sd2859, 16'sd1430, 16'sd4289, 16'sd12861, 16'sd6431,
      16'sd0, 16'sd6431, 16'sd3564, 16'sd2662, 16'sd4289, 16'sd696,
      16'sd6431, 16'sd0, 16'sd6431, 16'sd5001, 16'sd2662, 16'sd5001,
      16'sd2130, 16'sd32767,
      16'sd6431, 16'sd3564, 16'sd3564, 16'sd1966, 16'sd9421, 16'sd6431,
      16'sd9339, 16'sd2494, 16'sd2142, 16'sd1966, 16'sd1352, 16'sd6431,
      16'sd9339, 16'sd2494, 16'sd2142, 16'sd4289, 16'sd12861, 16'sd6431,
      16'sd0, 16'sd6431, 16'sd3072, 16'sd3072, 16'sd4289, 16'sd696,
      16'sd6431, 16'sd0, 16'sd6431, 16'sd4014, 16'sd4014, 16'sd5001,
      16'sd2130, 16'sd32767
   };

endpackage

// ===== sv/jpgf_csr.sv =====
// ----------------------------------------------------------------------------
// jpgf_csr
// APB register file holding the range margin and the jump limit.
// ----------------------------------------------------------------------------
module jpgf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [jpgf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready,
   output jpgf_pkg::cfg_type               cfg
);
   import jpgf_pkg::*;

   logic [CFG_W-1:0] margin_ff, margin_in;
   logic [CFG_W-1:0] jump_ff, jump_in;
   logic             wr_en;
   logic             reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      margin_in = margin_ff;
      jump_in   = jump_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_RANGE_MARGIN: margin_in = csr_pwdata[CFG_W-1:0];
            REG_MAX_JUMP:     jump_in   = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff <= MARGIN_RESET;
         jump_ff   <= JUMP_RESET;
      end else begin
         margin_ff <= margin_in;
         jump_ff   <= jump_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_RANGE_MARGIN: csr_prdata = {{(32-CFG_W){1'b0}}, margin_ff};
         REG_MAX_JUMP:     csr_prdata = {{(32-CFG_W){1'b0}}, jump_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.range_margin = margin_ff;
   assign cfg.max_jump     = jump_ff;

endmodule

// ===== sv/jpgf_held_mem.sv =====
// ----------------------------------------------------------------------------
// jpgf_held_mem
// Held position memory: one read and one write port, registered read data,
// per-entry valid bits for the zero reset and write-to-read forwarding.
// ----------------------------------------------------------------------------
module jpgf_held_mem (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  jpgf_pkg::slot_type  rd_slot,
   input  logic                wr_en,
   input  jpgf_pkg::slot_type  wr_slot,
   input  jpgf_pkg::pos_type   wr_data,
   output jpgf_pkg::pos_type   rd_data
);
   import jpgf_pkg::*;

   pos_type            mem_ff [SLOTS];
   pos_type            mem_rd_ff;
   logic [SLOTS-1:0]   valid_ff;
   logic               entry_valid_ff;
   logic               fwd_ff;
   pos_type            fwd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_slot] <= wr_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem_ff[rd_slot];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         entry_valid_ff <= 1'b0;
         fwd_ff         <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_slot] <= 1'b1;
         end
         if (rd_en) begin
            entry_valid_ff <= valid_ff[rd_slot];
            // write to the same entry in this cycle: take the new value
            fwd_ff         <= wr_en && (wr_slot == rd_slot);
         end
      end
   end

   assign rd_data = fwd_ff         ? fwd_data_ff :
                    entry_valid_ff ? mem_rd_ff   : '0;

endmodule

// ===== sv/joint_position_glitch_filter_unit.sv =====
// ----------------------------------------------------------------------------
// joint_position_glitch_filter_unit
// Path: req transfer loads s1 with the held memory read; the filter result is registered to rsp_tvalid.
// Throughput: one sample per cycle unless rsp_tready back-pressure stalls; held value memory does one
// read and one write per cycle, with forwarding between back-to-back samples of one axis.
// Reset: held values read as zero, first frame restarts, counter clears,
// registers return to margin 2048 and jump 2048; no clearing pass.
// ----------------------------------------------------------------------------
module joint_position_glitch_filter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [4:0] axis_index, [20:5] position_in, [23:21] zero
   input  logic [1:0]  req_tuser,  // [0] channel_kind, [1] not_finite
   input  logic        req_tlast,  // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [15:0] position_out, [31:16] rejected_frames
   output logic        rsp_tuser,  // [0] rejected
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import jpgf_pkg::*;

   cfg_type   cfg;
   logic      req_xfer;
   slot_type  req_slot;
   logic      req_filter;

   logic      s1_valid_ff, s1_valid_in;
   slot_type  s1_slot_ff;
   pos_type   s1_pos_ff;
   logic      s1_bad_ff;
   logic      s1_last_ff;
   logic      s1_filter_ff;
   logic      s1_fire;

   logic      out_valid_ff, out_valid_in;
   pos_type   out_pos_ff;
   logic      out_rej_ff;
   logic [COUNT_W-1:0] out_count_ff;
   logic      out_free;

   logic      first_done_ff, first_done_in;
   logic      had_rej_ff, had_rej_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   pos_type          held;
   logic signed [17:0] lim_lo, lim_hi, pos_x;
   logic signed [16:0] diff;
   logic [16:0]      diff_abs;
   logic             in_range;
   logic             sample_ok;
   logic             jump_ok;
   pos_type          result;
   logic             rej;
   logic             wr_en;

   jpgf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake
   assign out_free   = !out_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_xfer   = req_tvalid && req_tready;

   assign req_slot   = {req_tuser[0], req_tdata[4:0]};
   assign req_filter = (32'(req_tdata[4:0]) < AXES);

   jpgf_held_mem u_held (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_xfer),
      .rd_slot (req_slot),
      .wr_en   (wr_en),
      .wr_slot (s1_slot_ff),
      .wr_data (result),
      .rd_data (held)
   );

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_slot_ff   <= req_slot;
         s1_pos_ff    <= req_tdata[20:5];
         s1_bad_ff    <= req_tuser[1];
         s1_last_ff   <= req_tlast;
         s1_filter_ff <= req_filter;
      end
   end

   // filter decision
   always_comb begin
      pos_x     = 18'(s1_pos_ff);
      lim_lo    = 18'(LIMIT_LO[s1_slot_ff]) - 18'(cfg.range_margin);
      lim_hi    = 18'(LIMIT_HI[s1_slot_ff]) + 18'(cfg.range_margin);
      in_range  = (pos_x >= lim_lo) && (pos_x <= lim_hi);
      sample_ok = !s1_bad_ff && in_range;
      diff      = 17'(s1_pos_ff) - 17'(held);
      diff_abs  = diff[16] ? 17'(-diff) : 17'(diff);
      jump_ok   = (diff_abs <= 17'(cfg.max_jump));
      result    = '0;
      rej       = 1'b0;
      if (s1_filter_ff) begin
         if (!first_done_ff) begin
            result = sample_ok ? s1_pos_ff : '0;
         end else if (sample_ok && jump_ok) begin
            result = s1_pos_ff;
         end else begin
            result = held;
            rej    = 1'b1;
         end
      end
   end

   // held value unchanged on rejection: skip the write
   assign wr_en = s1_fire && s1_filter_ff && !rej;

   always_comb begin
      first_done_in = first_done_ff;
      had_rej_in    = had_rej_ff;
      count_in      = count_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            if (had_rej_ff || rej) begin
               count_in = count_ff + 1'b1;
            end
            had_rej_in    = 1'b0;
            first_done_in = 1'b1;
         end else if (rej) begin
            had_rej_in = 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         first_done_ff <= 1'b0;
         had_rej_ff    <= 1'b0;
         count_ff      <= '0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
         first_done_ff <= first_done_in;
         had_rej_ff    <= had_rej_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         out_pos_ff   <= result;
         out_rej_ff   <= rej;
         out_count_ff <= count_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_count_ff, out_pos_ff};
   assign rsp_tuser  = out_rej_ff;

endmodule
